// ===== src/chsq_pkg.sv =====
package chsq_pkg;

  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned CountW       = 16;
  localparam int unsigned AccW         = 48;
  localparam int unsigned DistW        = 24;

  typedef struct packed {
    logic [CountW-1:0] query_count;
    logic [CountW-1:0] ref_count;
    logic              last_bin;
  } chsq_in_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             saturated;
  } chsq_out_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkDiv,
    BkAdd,
    BkSqrt,
    BkOut
  } chsq_bk_state_e;

endpackage

// ===== src/chi_square_histogram_distance.sv =====
// chi-square histogram distance
// input channel: one beat per histogram bin, carrying the query count, the
// reference count and a last_bin flag; output channel: one beat per
// histogram, carrying the distance (unsigned, 8 fraction bits) and a flag
// telling whether the running sum saturated
// the front classifies each bin (sum, squared difference) into a two-entry
// queue; the back divides, accumulates and on the last bin takes the root
// the back takes one bin at a time and accepts the next only when idle; it
// divides with a radix-2 restoring divider; a bin with both counts zero
// skips the divider
// the last bin: its division, then the square root unit, then the result
// is presented from a register
// reset: accumulator and saturation flag clear, queue empty, no result
// pending; when the receiver stalls the result holds in the back, the queue
// fills and then in_ready_o drops
module chi_square_histogram_distance #(
  parameter int unsigned FracBits  = chsq_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  chsq_pkg::chsq_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output chsq_pkg::chsq_out_t out_data_o
);
  import chsq_pkg::*;

  // classified bin between front and back
  logic                q_valid, q_ready, q_last;
  logic [CountW:0]     q_sum;
  logic [2*CountW-1:0] q_sq;

  chsq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_sum_o(q_sum),
    .q_sq_o(q_sq), .q_last_o(q_last)
  );

  chsq_back #(.FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_sum_i(q_sum), .q_sq_i(q_sq), .q_last_i(q_last),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

// ===== src/chsq_front.sv =====
module chsq_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  chsq_pkg::chsq_in_t              in_data_i,
  output logic                            q_valid_o,
  input  logic                            q_ready_i,
  output logic [chsq_pkg::CountW:0]       q_sum_o,
  output logic [2*chsq_pkg::CountW-1:0]   q_sq_o,
  output logic                            q_last_o
);
  import chsq_pkg::*;

  // two-entry queue of classified bins: sum and squared difference
  logic [CountW:0]     sum_q [2];
  logic [2*CountW-1:0] sq_q [2];
  logic [1:0]          last_q;
  logic                wp_q, rp_q;
  logic [1:0]          cnt_q;

  logic [CountW-1:0] q, r, diff;
  logic              push, pop;

  assign q    = in_data_i.query_count[CountW-1:0];
  assign r    = in_data_i.ref_count[CountW-1:0];
  assign diff = (r >= q) ? (r - q) : (q - r);

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;

  assign q_sum_o  = sum_q[rp_q];
  assign q_sq_o   = sq_q[rp_q];
  assign q_last_o = last_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      sum_q[wp_q]  <= {1'b0, q} + {1'b0, r};
      sq_q[wp_q]   <= diff * diff;
      last_q[wp_q] <= in_data_i.last_bin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/chsq_back.sv =====
module chsq_back #(
  parameter int unsigned FracBits  = chsq_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  logic [chsq_pkg::CountW:0]     q_sum_i,
  input  logic [2*chsq_pkg::CountW-1:0] q_sq_i,
  input  logic                          q_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output chsq_pkg::chsq_out_t           out_data_o
);
  import chsq_pkg::*;

  localparam int unsigned NumW  = 2*CountW + FracBits;
  localparam int unsigned DenW  = CountW + 1;
  localparam int unsigned StepW = $clog2(NumW + 1);
  localparam int unsigned SqSteps = AccW / 2;
  localparam int unsigned SqCntW  = $clog2(SqSteps + 1);
  localparam logic [AccW-1:0] AccMax = '1;

  chsq_bk_state_e state_q, state_d;

  logic [NumW-1:0]  quo_q;
  logic [DenW:0]    rem_q;
  logic [DenW-1:0]  den_q;
  logic [StepW-1:0] step_q;
  logic             last_q;
  logic [AccW-1:0]  acc_q;
  logic             sat_q;
  logic [AccW-1:0]  sv_q;
  logic [AccW-1:0]  sres_q;
  logic [AccW+1:0]  srem_q;
  logic [SqCntW-1:0] scnt_q;
  chsq_out_t        res_q;

  logic [DenW:0]   rem_sh;
  logic            ge;
  logic [AccW:0]   acc_sum;
  logic [AccW+1:0] srem_sh, strial;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q[DenW-1:0], quo_q[NumW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign acc_sum = {1'b0, acc_q} + {{(AccW-NumW+1){1'b0}}, quo_q};
  // digit-by-digit square root, two radicand bits per cycle
  assign srem_sh = {srem_q[AccW-1:0], sv_q[AccW-1 -: 2]};
  assign strial  = {sres_q, 2'b01};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: if (q_valid_i) state_d = (q_sum_i == '0) ? BkAdd : BkDiv;
      BkDiv:  if (step_q == StepW'(1)) state_d = BkAdd;
      BkAdd:  state_d = last_q ? BkSqrt : BkIdle;
      BkSqrt: if (scnt_q == SqCntW'(1)) state_d = BkOut;
      BkOut:  if (out_ready_i) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    q_ready_o   = (state_q == BkIdle);
    out_valid_o = (state_q == BkOut);
    out_data_o  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      acc_q   <= '0;
      sat_q   <= 1'b0;
      step_q  <= '0;
      scnt_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        BkIdle: if (q_valid_i) begin
          last_q <= q_last_i;
          step_q <= StepW'(NumW);
        end
        BkDiv: step_q <= step_q - StepW'(1);
        BkAdd: begin
          if (acc_sum[AccW]) begin
            acc_q <= AccMax;
            sat_q <= 1'b1;
          end else begin
            acc_q <= acc_sum[AccW-1:0];
          end
          if (last_q) scnt_q <= SqCntW'(SqSteps);
        end
        BkSqrt: begin
          scnt_q <= scnt_q - SqCntW'(1);
          if (scnt_q == SqCntW'(1)) begin
            acc_q <= '0;
            sat_q <= 1'b0;
          end
        end
        BkOut: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BkIdle: begin
        quo_q <= (q_sum_i == '0) ? '0 : {q_sq_i, {FracBits{1'b0}}};
        rem_q <= '0;
        den_q <= q_sum_i;
      end
      BkDiv: begin
        rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
        quo_q <= {quo_q[NumW-2:0], ge};
      end
      BkAdd: begin
        sv_q   <= acc_sum[AccW] ? AccMax : acc_sum[AccW-1:0];
        sres_q <= '0;
        srem_q <= '0;
      end
      BkSqrt: begin
        sv_q <= {sv_q[AccW-3:0], 2'b00};
        if (srem_sh >= strial) begin
          srem_q <= srem_sh - strial;
          sres_q <= {sres_q[AccW-2:0], 1'b1};
        end else begin
          srem_q <= srem_sh;
          sres_q <= {sres_q[AccW-2:0], 1'b0};
        end
        if (scnt_q == SqCntW'(1)) begin
          res_q.distance  <= (srem_sh >= strial) ? {sres_q[DistW-2:0], 1'b1}
                                                 : {sres_q[DistW-2:0], 1'b0};
          res_q.saturated <= sat_q;
        end
      end
      BkOut: ;
      default: ;
    endcase
  end

endmodule

// ===== src/chsq_checker.sv =====
module chsq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input chsq_pkg::chsq_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input chsq_pkg::chsq_out_t out_data_o
);
  // an offered bin stays unchanged until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("bin dropped or changed");
  // a result beat stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o)) else $error("result changed");
  // no result right after reset release
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result out of reset");
  // a result cannot follow a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o) else $error("results too close");
endmodule

bind chi_square_histogram_distance chsq_checker u_chsq_checker (.*);
